/* src/md5_style_block_hash_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the MD5-style block hash core
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MD5_STYLE_BLOCK_HASH_CORE_ASSERT_SVH
`define MD5_STYLE_BLOCK_HASH_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HASH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HASH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash core assertion failed");

`endif

/* src/md5s_pkg.sv */
// ----------------------------------------------------------------------------
// MD5-style hash package
// Payload types, control structs, reset constants and round tables.
// ----------------------------------------------------------------------------
package md5s_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } msg_t;

    typedef struct packed {
        logic [31:0] digest_a;
        logic [31:0] digest_b;
        logic [31:0] digest_c;
        logic [31:0] digest_d;
    } digest_t;

    typedef struct packed {
        logic start;
        logic restart;
    } cmp_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cmp_stat_t;

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_A = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_B = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_C = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_D = 4'd3;

    localparam logic [31:0] RESET_A = 32'h01234567;
    localparam logic [31:0] RESET_B = 32'h89abcdef;
    localparam logic [31:0] RESET_C = 32'hfedcba98;
    localparam logic [31:0] RESET_D = 32'h76543210;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMOUNT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word used by a given round.
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = rnd[3:0];
        case (rnd[5:4])
            2'd0: idx = lo;
            2'd1: idx = 4'(lo * 4'd5 + 4'd1);
            2'd2: idx = 4'(lo * 4'd3 + 4'd5);
            default: idx = 4'(lo * 4'd7);
        endcase
        return idx;
    endfunction

endpackage

/* src/md5s_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module md5s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/md5s_round.sv */
// ----------------------------------------------------------------------------
// MD5-style round unit
// Computes the new second working word for one round of the compression.
// ----------------------------------------------------------------------------
module md5s_round
    import md5s_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] m_word,
    input  logic [5:0]  rnd,
    output logic [31:0] b_new
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  sh;
    logic [31:0] rotated;

    always_comb
    begin
        case (rnd[5:4])
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        sum = a + f + m_word + ROUND_ADD[rnd];
        sh = ROT_AMOUNT[{rnd[5:4], rnd[1:0]}];
        rotated = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
        b_new = b + rotated;
    end

endmodule

/* src/md5s_compress.sv */
// ----------------------------------------------------------------------------
// MD5-style compression engine
// Runs 64 rounds, one per cycle, through the round unit, then adds the
// working words into the chaining words.
// ----------------------------------------------------------------------------
module md5s_compress
    import md5s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmp_ctrl_t   ctrl,
    input  digest_t     init,
    input  logic [31:0] m_word,
    output logic [3:0]  rd_addr,
    output cmp_stat_t   stat,
    output digest_t     chain
);

    logic        busy_reg, busy_next;
    logic        add_reg, add_next;
    logic [5:0]  round_reg, round_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] c_reg, c_next;
    logic [31:0] d_reg, d_next;
    digest_t     chain_reg, chain_next;
    logic [31:0] round_b;

    md5s_round u_round (
        .a      (a_reg),
        .b      (b_reg),
        .c      (c_reg),
        .d      (d_reg),
        .m_word (m_word),
        .rnd    (round_reg),
        .b_new  (round_b)
    );

    always_comb
    begin
        busy_next  = busy_reg;
        add_next   = 1'b0;
        round_next = round_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        chain_next = chain_reg;
        if (ctrl.start)
        begin
            busy_next  = 1'b1;
            round_next = '0;
            a_next     = chain_reg.digest_a;
            b_next     = chain_reg.digest_b;
            c_next     = chain_reg.digest_c;
            d_next     = chain_reg.digest_d;
        end
        else if (busy_reg)
        begin
            a_next     = d_reg;
            b_next     = round_b;
            c_next     = b_reg;
            d_next     = c_reg;
            round_next = round_reg + 6'd1;
            if (round_reg == 6'd63)
            begin
                busy_next = 1'b0;
                add_next  = 1'b1;
            end
        end
        if (add_reg)
        begin
            chain_next.digest_a = chain_reg.digest_a + a_reg;
            chain_next.digest_b = chain_reg.digest_b + b_reg;
            chain_next.digest_c = chain_reg.digest_c + c_reg;
            chain_next.digest_d = chain_reg.digest_d + d_reg;
        end
        if (ctrl.restart)
        begin
            chain_next = init;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            add_reg   <= 1'b0;
            round_reg <= '0;
            chain_reg <= '{digest_a: RESET_A, digest_b: RESET_B,
                           digest_c: RESET_C, digest_d: RESET_D};
        end
        else
        begin
            busy_reg  <= busy_next;
            add_reg   <= add_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign rd_addr   = busy_reg ? msg_index(round_reg + 6'd1) : 4'd0;
    assign stat.busy = busy_reg | add_reg;
    assign stat.done = add_reg;
    assign chain     = chain_reg;

endmodule

/* src/md5_style_block_hash_core.sv */
// ----------------------------------------------------------------------------
// MD5-style block hash core
// Packs message bytes into a 16-word block, compresses each full block and
// emits the four chaining words when a message is finished.
//
// Channel   Direction  Handshake                    Contents
// msg       in         msg_valid / msg_stall        action, data_byte
// digest    out        digest_valid / digest_stall  digest_a .. digest_d
// cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A data byte is written without stalling the msg channel; the 64th byte of a
// block then runs the compression engine: its start, 64 rounds and chaining add.
// A finish writes the padding bytes, runs one compression and, when the pad
// byte lands at position 60 or later, clears the block and runs a second
// compression, then loads the digest register.
// The msg channel stalls while a block is padded out, cleared or compressed and while the digest waits to load.
// A held digest stalls only the next finish, at its final load.
// ----------------------------------------------------------------------------
`include "md5_style_block_hash_core_assert.svh"

module md5_style_block_hash_core
    import md5s_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 msg_valid,
    output logic                 msg_stall,
    input  msg_t                 msg,
    output logic                 digest_valid,
    input  logic                 digest_stall,
    output digest_t              digest,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    localparam logic [1:0] MODE_DATA = 2'd0;
    localparam logic [1:0] MODE_WRAP = 2'd1;
    localparam logic [1:0] MODE_LAST = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  mode_reg, mode_next;
    logic [5:0]  fill_reg, fill_next;
    logic [6:0]  pad_reg, pad_next;
    logic [3:0]  clr_reg, clr_next;
    logic [31:0] total_reg, total_next;
    digest_t     init_reg, init_next;
    logic        dig_valid_reg, dig_valid_next;
    digest_t     digest_reg, digest_next;

    logic        msg_accept;
    logic        load_dig;
    logic [3:0]  we_lane;
    logic [3:0]  waddr;
    logic [31:0] wdata;
    logic [3:0]  rd_addr;
    logic [31:0] m_word;
    cmp_ctrl_t   cmp_ctrl;
    cmp_stat_t   cmp_stat;
    digest_t     chain;

    for (genvar lane = 0; lane < 4; lane++)
    begin : g_lane
        md5s_ram #(
            .WIDTH (8),
            .DEPTH (16)
        ) u_ram (
            .clk   (clk),
            .we    (we_lane[lane]),
            .waddr (waddr),
            .wdata (wdata[8*lane +: 8]),
            .raddr (rd_addr),
            .rdata (m_word[8*lane +: 8])
        );
    end

    md5s_compress u_compress (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cmp_ctrl),
        .init    (init_reg),
        .m_word  (m_word),
        .rd_addr (rd_addr),
        .stat    (cmp_stat),
        .chain   (chain)
    );

    assign msg_stall  = (state_reg != ST_IDLE);
    assign msg_accept = msg_valid && !msg_stall;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        fill_next        = fill_reg;
        pad_next         = pad_reg;
        clr_next         = clr_reg;
        total_next       = total_reg;
        we_lane          = 4'b0000;
        waddr            = fill_reg[5:2];
        wdata            = '0;
        cmp_ctrl.start   = 1'b0;
        cmp_ctrl.restart = 1'b0;
        load_dig         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_accept)
                begin
                    we_lane = 4'b0001 << fill_reg[1:0];
                    waddr   = fill_reg[5:2];
                    if (!msg.action)
                    begin
                        wdata      = {4{msg.data_byte}};
                        total_next = total_reg + 32'd1;
                        fill_next  = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            mode_next  = MODE_DATA;
                            state_next = ST_START;
                        end
                    end
                    else
                    begin
                        wdata      = {4{PAD_BYTE}};
                        pad_next   = {1'b0, fill_reg} + 7'd1;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_reg == 7'd64)
                begin
                    mode_next  = MODE_WRAP;
                    state_next = ST_START;
                end
                else if (pad_reg == 7'd60)
                begin
                    we_lane    = 4'b1111;
                    waddr      = 4'd15;
                    wdata      = total_reg;
                    mode_next  = MODE_LAST;
                    state_next = ST_START;
                end
                else
                begin
                    we_lane  = 4'b0001 << pad_reg[1:0];
                    waddr    = pad_reg[5:2];
                    pad_next = pad_reg + 7'd1;
                end
            end
            ST_CLEAR:
            begin
                we_lane = 4'b1111;
                waddr   = clr_reg;
                if (clr_reg == 4'd15)
                begin
                    wdata      = total_reg;
                    mode_next  = MODE_LAST;
                    state_next = ST_START;
                end
                else
                begin
                    clr_next = clr_reg + 4'd1;
                end
            end
            ST_START:
            begin
                cmp_ctrl.start = 1'b1;
                state_next     = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (cmp_stat.done)
                begin
                    case (mode_reg)
                        MODE_WRAP:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        MODE_LAST: state_next = ST_EMIT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (!dig_valid_reg || !digest_stall)
                begin
                    load_dig         = 1'b1;
                    cmp_ctrl.restart = 1'b1;
                    fill_next        = '0;
                    total_next       = '0;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        dig_valid_next = dig_valid_reg;
        digest_next    = digest_reg;
        if (dig_valid_reg && !digest_stall)
        begin
            dig_valid_next = 1'b0;
        end
        if (load_dig)
        begin
            dig_valid_next = 1'b1;
            digest_next    = chain;
        end
    end

    always_comb
    begin
        init_next = init_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INIT_A: init_next.digest_a = cfg_data;
                CFG_INIT_B: init_next.digest_b = cfg_data;
                CFG_INIT_C: init_next.digest_c = cfg_data;
                CFG_INIT_D: init_next.digest_d = cfg_data;
                default:    init_next = init_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_DATA;
            fill_reg      <= '0;
            pad_reg       <= '0;
            clr_reg       <= '0;
            total_reg     <= '0;
            dig_valid_reg <= 1'b0;
            init_reg      <= '{digest_a: RESET_A, digest_b: RESET_B,
                              digest_c: RESET_C, digest_d: RESET_D};
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            fill_reg      <= fill_next;
            pad_reg       <= pad_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            dig_valid_reg <= dig_valid_next;
            init_reg      <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digest_reg <= digest_next;
    end

    assign digest_valid = dig_valid_reg;
    assign digest       = digest_reg;

    `HASH_ASSERT_SAME(a_busy_in_wait, clk, rst_n, cmp_stat.busy, state_reg == ST_WAIT)
    `HASH_ASSERT_SAME(a_pad_bound, clk, rst_n, state_reg == ST_PAD, pad_reg <= 7'd64)
    `HASH_ASSERT_NEXT(a_full_block_starts, clk, rst_n, msg_accept && !msg.action && fill_reg == 6'd63, state_reg == ST_START)
    `HASH_ASSERT_NEXT(a_emit_restarts, clk, rst_n, load_dig, fill_reg == 6'd0 && total_reg == 32'd0 && digest_valid)

endmodule
